### design/scfd_pkg.sv
`timescale 1ns / 1ps

package scfd_pkg;

  // command letters
  localparam logic [7:0] LETTER_M = 8'h4D;
  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_F = 8'h46;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  // request kinds on the input tuser bit
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // flow control codes
  localparam logic [1:0] FLOW_NONE = 2'd0;
  localparam logic [1:0] FLOW_STOP = 2'd1;
  localparam logic [1:0] FLOW_CONT = 2'd2;

  // register index, taken from paddr bit 2
  localparam logic REG_STOP_LEVEL   = 1'b0;
  localparam logic REG_RESUME_LEVEL = 1'b1;

  localparam logic [7:0]  STOP_LEVEL_RST   = 8'd130;
  localparam logic [7:0]  RESUME_LEVEL_RST = 8'd125;
  localparam logic [15:0] PERIOD_RST       = 16'd255;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_EX   = 6'b001000,
    ST_NX   = 6'b010000,
    ST_DONE = 6'b100000
  } st_t;

endpackage

### design/stepper_command_fifo_dispatcher_top.sv
`timescale 1ns / 1ps

// Stepper command ring buffer with stop/continue flow control.
// Input channel (in_*): one beat is either a received command pair
// (in_tuser = 0, letter and value in in_tdata) or one prescaled timer tick
// (in_tuser = 1). Every beat gives exactly one result beat on out_*.
// A receive goes from ST_IDLE straight to ST_DONE, as does a tick without
// a timer match. A match walks the ring: ST_CHK does the empty check and
// first read, then ST_EX and ST_NX take each dispatched entry, with one
// registered memory read each. The walk stops at the next step command, at
// an empty store, or at its bound of ENTRIES + 1 entries.
// One item is handled at a time; a new beat is taken once the previous
// result has been moved into the output register, so one result may wait
// on a stalled receiver while the next item is accepted. A stalled receiver
// holds the result in out_tdata until out_tready.
// After reset the command store is cleared by a pass over all ENTRIES slots,
// during which in_tready is low; register writes on the cfg_ port are
// taken at any time.
module stepper_command_fifo_dispatcher_top #(
  parameter int ENTRIES      = 150,
  parameter int MOTORS       = 4,
  parameter int TICKS_PER_MS = 62
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd_code [7:0], cmd_value [15:8]
  input  logic [scfd_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type [0]
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // accepted [0], step_mask [4:1], dir_mask [8:5], motor_enable [12:9],
  // flow_signal [14:13], underflow_led [15], overflow_led [16], zero [23:17]
  output logic [scfd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [2:0]                      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import scfd_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = $clog2(ENTRIES + 2);
  localparam logic [3:0] MOTOR_MASK = 4'((1 << MOTORS) - 1);

  st_t              st_r, st_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [AW-1:0]    wr_r, wr_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             stop_r, stop_nxt;
  logic [15:0]      period_r, period_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [3:0]       en_r, en_nxt;
  logic             under_r, under_nxt;
  logic             over_r, over_nxt;
  logic [7:0]       stop_lvl_r, resume_lvl_r;
  logic [WW-1:0]    walk_r, walk_nxt;
  logic             acc_r, acc_nxt;
  logic [3:0]       steps_r, steps_nxt;
  logic [3:0]       dirs_r, dirs_nxt;
  logic [1:0]       flow_r, flow_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [15:0]      mem [ENTRIES];
  logic [15:0]      rdata_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;

  logic [AW-1:0]    rd_inc, wr_inc;
  logic [7:0]       cnt_inc, cnt_dec;
  logic [WW-1:0]    walk_inc;
  logic             not_empty;
  logic [7:0]       ex_val;
  logic [15:0]      f_product;
  logic             cfg_wr;

  assign rd_inc    = (rd_r == AW'(ENTRIES - 1)) ? '0 : rd_r + AW'(1);
  assign wr_inc    = (wr_r == AW'(ENTRIES - 1)) ? '0 : wr_r + AW'(1);
  assign cnt_inc   = cnt_r + 8'd1;
  assign cnt_dec   = cnt_r - 8'd1;
  assign walk_inc  = walk_r + WW'(1);
  assign not_empty = (rd_r != wr_r) || stop_r;
  assign ex_val    = rdata_r[7:0];
  assign f_product = {8'd0, ex_val} * 16'(TICKS_PER_MS);

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_RESUME_LEVEL) ? {24'd0, resume_lvl_r}
                                                         : {24'd0, stop_lvl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_lvl_r   <= STOP_LEVEL_RST;
      resume_lvl_r <= RESUME_LEVEL_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_STOP_LEVEL) begin
        stop_lvl_r <= cfg_pwdata[7:0];
      end else begin
        resume_lvl_r <= cfg_pwdata[7:0];
      end
    end
  end

  // command store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    cnt_nxt       = cnt_r;
    stop_nxt      = stop_r;
    period_nxt    = period_r;
    tick_nxt      = tick_r;
    en_nxt        = en_r;
    under_nxt     = under_r;
    over_nxt      = over_r;
    walk_nxt      = walk_r;
    acc_nxt       = acc_r;
    steps_nxt     = steps_r;
    dirs_nxt      = dirs_r;
    flow_nxt      = flow_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_r;
    // letter in the upper byte of a stored entry
    mem_wdata     = {in_tdata[7:0], in_tdata[15:8]};
    mem_re        = 1'b0;
    mem_raddr     = rd_r;

    case (st_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == AW'(ENTRIES - 1)) begin
          st_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          acc_nxt   = 1'b0;
          steps_nxt = '0;
          dirs_nxt  = '0;
          flow_nxt  = FLOW_NONE;
          st_nxt    = ST_DONE;
          if (in_tuser[0] == REQ_RX) begin
            if (stop_r && (rd_r == wr_r)) begin
              over_nxt = 1'b1;
            end else begin
              mem_we  = 1'b1;
              wr_nxt  = wr_inc;
              cnt_nxt = cnt_inc;
              acc_nxt = 1'b1;
              if (cnt_inc >= stop_lvl_r) begin
                stop_nxt = 1'b1;
                flow_nxt = FLOW_STOP;
              end
            end
          end else if (tick_r == period_r) begin
            tick_nxt = '0;
            walk_nxt = '0;
            st_nxt   = ST_CHK;
          end else begin
            tick_nxt = tick_r + 16'd1;
          end
        end
      end
      ST_CHK: begin
        if (not_empty) begin
          mem_re = 1'b1;
          st_nxt = ST_EX;
        end else begin
          under_nxt = 1'b1;
          st_nxt    = ST_DONE;
        end
      end
      ST_EX: begin
        case (rdata_r[15:8])
          LETTER_A: en_nxt = (ex_val == CHAR_ONE) ? MOTOR_MASK : 4'd0;
          LETTER_M: begin
            steps_nxt = ex_val[3:0] & MOTOR_MASK;
            dirs_nxt  = ex_val[7:4] & ex_val[3:0] & MOTOR_MASK;
          end
          LETTER_F: period_nxt = f_product;
          default: ;
        endcase
        rd_nxt    = rd_inc;
        cnt_nxt   = cnt_dec;
        under_nxt = 1'b0;
        walk_nxt  = walk_inc;
        if (stop_r && (cnt_dec < resume_lvl_r)) begin
          stop_nxt = 1'b0;
          flow_nxt = FLOW_CONT;
        end
        if (walk_inc > WW'(ENTRIES)) begin
          st_nxt = ST_DONE;
        end else begin
          // fetch the following slot to look for the next step command
          mem_re    = 1'b1;
          mem_raddr = rd_inc;
          st_nxt    = ST_NX;
        end
      end
      ST_NX: begin
        if (rdata_r[15:8] == LETTER_M) begin
          st_nxt = ST_DONE;
        end else if (not_empty) begin
          st_nxt = ST_EX;
        end else begin
          under_nxt = 1'b1;
          st_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, over_r, under_r, flow_r, en_r, dirs_r, steps_r, acc_r};
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_r       <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      stop_r      <= 1'b0;
      period_r    <= PERIOD_RST;
      tick_r      <= '0;
      en_r        <= '0;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      cnt_r       <= cnt_nxt;
      stop_r      <= stop_nxt;
      period_r    <= period_nxt;
      tick_r      <= tick_nxt;
      en_r        <= en_nxt;
      under_r     <= under_nxt;
      over_r      <= over_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    steps_r    <= steps_nxt;
    dirs_r     <= dirs_nxt;
    flow_r     <= flow_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // the store is only written while no walk is reading it
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHK || st_r == ST_EX || st_r == ST_NX) |-> !mem_we)
    else $error("command store written during a dispatch walk");

  // a walk never examines more than ENTRIES + 1 slots
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EX) |-> (walk_r <= WW'(ENTRIES)))
    else $error("dispatch walk ran past its bound");

  // stop is only raised by an accepted receive beat
  a_stop_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stop_r) |-> $past(in_tvalid && in_tready && (in_tuser[0] == REQ_RX)))
    else $error("stop flag raised without a receive beat");

  // a finished item reaches the output register
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && (!out_valid_r || out_tready)) |=> out_tvalid)
    else $error("result beat not presented");
`endif

endmodule

### verif/tb_stepper_command_fifo_dispatcher_top.sv
`timescale 1ns / 1ps

module tb_stepper_command_fifo_dispatcher_top;
  import scfd_pkg::*;

  localparam int RING_SLOTS     = 150;
  localparam int MOTOR_COUNT    = 4;
  localparam int TICK_SCALE     = 62;
  localparam logic [3:0] MOTOR_MASK = 4'((1 << MOTOR_COUNT) - 1);
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_OFF       = 300;
  localparam int IDLE_PCT       = 32;

  // one result beat, lowest field last
  typedef struct packed {
    logic [6:0] pad;
    logic       overflow_led;
    logic       underflow_led;
    logic [1:0] flow_signal;
    logic [3:0] motor_enable;
    logic [3:0] dir_mask;
    logic [3:0] step_mask;
    logic       accepted;
  } status_t;

  class dispatch_scoreboard;
    logic [15:0] cmd_ring [RING_SLOTS];
    int unsigned rd_slot, wr_slot;
    logic [7:0]  backlog, stop_lvl, resume_lvl;
    logic [15:0] period, tick_cnt;
    logic [3:0]  enables;
    bit          stop_on, empty_seen, dropped_seen;
    status_t     status_due[$];
    int          failures;

    function new();
      foreach (cmd_ring[i]) cmd_ring[i] = '0;
      rd_slot      = 0;
      wr_slot      = 0;
      backlog      = '0;
      stop_lvl     = STOP_LEVEL_RST;
      resume_lvl   = RESUME_LEVEL_RST;
      period       = PERIOD_RST;
      tick_cnt     = '0;
      enables      = '0;
      stop_on      = 1'b0;
      empty_seen   = 1'b0;
      dropped_seen = 1'b0;
      failures     = 0;
    endfunction

    function void set_level(logic idx, logic [7:0] val);
      if (idx == REG_STOP_LEVEL) stop_lvl = val;
      else resume_lvl = val;
    endfunction

    function void note_command(logic kind, logic [7:0] code, logic [7:0] value);
      status_t     s;
      int unsigned walked;
      logic [15:0] entry;
      s = '0;
      walked = 0;
      if (kind == REQ_RX) begin
        if (stop_on && rd_slot == wr_slot) begin
          dropped_seen = 1'b1;
        end else begin
          cmd_ring[wr_slot] = {code, value};
          wr_slot = (wr_slot == RING_SLOTS - 1) ? 0 : wr_slot + 1;
          backlog++;
          s.accepted = 1'b1;
          if (backlog >= stop_lvl) begin
            stop_on = 1'b1;
            s.flow_signal = FLOW_STOP;
          end
        end
      end else if (tick_cnt != period) begin
        tick_cnt++;
      end else begin
        tick_cnt = '0;
        // a set stop flag makes equal slots count as full, so stale slots get replayed
        while (1) begin
          if (rd_slot == wr_slot && !stop_on) begin
            empty_seen = 1'b1;
            break;
          end
          entry = cmd_ring[rd_slot];
          if (entry[15:8] == LETTER_A) begin
            enables = (entry[7:0] == CHAR_ONE) ? MOTOR_MASK : 4'h0;
          end else if (entry[15:8] == LETTER_M) begin
            s.step_mask = entry[3:0] & MOTOR_MASK;
            s.dir_mask  = entry[7:4] & s.step_mask;
          end else if (entry[15:8] == LETTER_F) begin
            period = 16'(entry[7:0] * TICK_SCALE);
          end
          rd_slot = (rd_slot == RING_SLOTS - 1) ? 0 : rd_slot + 1;
          backlog--;
          if (stop_on && backlog < resume_lvl) begin
            stop_on = 1'b0;
            s.flow_signal = FLOW_CONT;
          end
          empty_seen = 1'b0;
          walked++;
          if (walked > RING_SLOTS || cmd_ring[rd_slot][15:8] == LETTER_M) break;
        end
      end
      s.motor_enable  = enables;
      s.underflow_led = empty_seen;
      s.overflow_led  = dropped_seen;
      status_due.push_back(s);
    endfunction

    function string describe(status_t v);
      return $sformatf("acc=%0d step=%h dir=%h en=%h flow=%0d under=%0d over=%0d",
                       v.accepted, v.step_mask, v.dir_mask, v.motor_enable,
                       v.flow_signal, v.underflow_led, v.overflow_led);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result beat with nothing due: %s", $time, describe(got));
        return;
      end
      want = status_due.pop_front();
      if (got.accepted !== want.accepted || got.step_mask !== want.step_mask ||
          got.dir_mask !== want.dir_mask || got.motor_enable !== want.motor_enable ||
          got.flow_signal !== want.flow_signal ||
          got.underflow_led !== want.underflow_led ||
          got.overflow_led !== want.overflow_led) begin
        failures++;
        if (failures <= 10)
          $display("%0t: expected %s, got %s", $time, describe(want), describe(got));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [2:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  bit calm = 1'b0;
  int hold_request = 0;
  dispatch_scoreboard sb = new();

  stepper_command_fifo_dispatcher_top #(
    .ENTRIES      (RING_SLOTS),
    .MOTORS       (MOTOR_COUNT),
    .TICKS_PER_MS (TICK_SCALE)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_beat(input logic kind, input logic [7:0] code, input logic [7:0] value);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(kind, code, value);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_level(idx, val);
  endtask

  // sender goes quiet until every result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] stop_at, input logic [7:0] resume_below,
                           input int count, input int rx_pct, input bit quiet,
                           input bit squeeze);
    int         pick;
    logic [7:0] code, value;
    settle();
    write_reg(REG_STOP_LEVEL, stop_at);
    write_reg(REG_RESUME_LEVEL, resume_below);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 2) hold_request = HOLD_OFF;
      if ($urandom_range(0, 99) < rx_pct) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          code  = LETTER_M;
          value = 8'($urandom_range(0, 255));
        end else if (pick < 11) begin
          code  = LETTER_A;
          value = $urandom_range(0, 1) ? CHAR_ONE : 8'($urandom_range(0, 255));
        end else if (pick < 13) begin
          // keep periods short so matches stay frequent
          code  = LETTER_F;
          value = ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 2));
        end else begin
          code  = 8'($urandom_range(0, 255));
          value = (code == LETTER_F) ? 8'd0 : 8'($urandom_range(0, 255));
        end
        send_beat(REQ_RX, code, value);
      end else begin
        send_beat(REQ_TICK, 8'($urandom), 8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin : receiver
    forever begin
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_status(status_t'(out_tdata));
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_STOP_LEVEL, 8'd2);
    write_reg(REG_RESUME_LEVEL, 8'd1);

    // reset period is 255, so the stored F 0 goes out on the 256th tick
    send_beat(REQ_RX, LETTER_F, 8'h00);
    repeat (256) send_beat(REQ_TICK, 8'($urandom), 8'($urandom));

    // no M in the ring and a stop flag that never clears: walk hits its bound,
    // leaves the slots equal, then receives are dropped
    settle();
    write_reg(REG_STOP_LEVEL, 8'd0);
    write_reg(REG_RESUME_LEVEL, 8'd0);
    send_beat(REQ_RX, LETTER_A, CHAR_ONE);
    send_beat(REQ_TICK, 8'hFF, 8'hFF);
    send_beat(REQ_RX, 8'h12, 8'h34);
    send_beat(REQ_RX, 8'hFF, 8'hFF);

    settle();
    write_reg(REG_STOP_LEVEL, 8'd2);
    write_reg(REG_RESUME_LEVEL, 8'd150);
    send_beat(REQ_TICK, 8'h00, 8'h00);
    send_beat(REQ_RX, LETTER_M, 8'hFF);
    send_beat(REQ_RX, LETTER_M, 8'h00);
    send_beat(REQ_RX, LETTER_A, CHAR_ONE);
    send_beat(REQ_RX, 8'hFF, 8'hA5);
    send_beat(REQ_RX, LETTER_F, 8'hFF);
    send_beat(REQ_RX, LETTER_F, 8'h00);
    send_beat(REQ_RX, LETTER_M, 8'h5A);
    send_beat(REQ_RX, LETTER_A, 8'h00);
    send_beat(REQ_RX, 8'h00, 8'hFF);
    repeat (5) send_beat(REQ_TICK, 8'hFF, 8'h00);

    run_phase(8'd130, 8'd125, 100, 85, 1'b0, 1'b0);
    run_phase(8'd10,  8'd5,    80, 60, 1'b0, 1'b0);
    run_phase(8'd0,   8'd0,    40, 50, 1'b0, 1'b0);
    run_phase(8'd150, 8'd150,  80, 75, 1'b1, 1'b0);
    run_phase(8'd200, 8'd100, 110, 90, 1'b0, 1'b1);
    run_phase(8'd40,  8'd30,   64, 25, 1'b0, 1'b0);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.status_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
